@@ hdl/tfe_pkg.sv @@
// Package for the telemetry frame encoder.
// Holds frame constants, the frame type and the end-around-carry add.
// No dependencies.
package tfe_pkg;

    localparam logic [7:0] FRAME_TYPE = 8'h10;
    localparam logic [7:0] START_MARK = 8'h7E;
    localparam logic [7:0] ESC_MARK   = 8'h7D;
    localparam logic [7:0] ESC_FLIP   = 8'h20;
    localparam logic [7:0] CHECK_BASE = 8'hFF;
    localparam logic [7:0] BYTE_MASK  = 8'hFF;

    localparam int FRAME_BYTES = 8;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    // unescaped frame, byte 0 goes out first
    typedef logic [FRAME_BYTES-1:0][7:0] t_frame;

    // 8-bit add with the carry folded back in
    function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'b0, s[8]};
    endfunction

    function automatic logic needs_esc(input logic [7:0] b);
        return (b == START_MARK) || (b == ESC_MARK);
    endfunction

endpackage

@@ hdl/telemetry_frame_encoder.sv @@
// Telemetry data frame encoder: one item in, 8 to 15 escaped wire bytes out.
// The serializer emits one word per cycle while i_ready is high and takes the next frame
// as the last word of the current one goes out, while three check-byte stages fill behind it.
// Reset: synchronous, active low; clears all valid bits and the serializer.
// Depends on tfe_pkg, tfe_check and tfe_serial.
module telemetry_frame_encoder
    import tfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_sensor_id,
    input  logic [31:0] i_data_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_wire_byte,
    output logic        o_frame_end
);

    logic   chk_valid;
    logic   ser_ready;
    t_frame chk_frame;

    tfe_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sensor_id  (i_sensor_id),
        .i_data_value (i_data_value),
        .o_valid      (chk_valid),
        .i_ready      (ser_ready),
        .o_frame      (chk_frame)
    );

    tfe_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (chk_valid),
        .o_ready     (ser_ready),
        .i_frame     (chk_frame),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_wire_byte (o_wire_byte),
        .o_frame_end (o_frame_end)
    );

endmodule

@@ hdl/tfe_check.sv @@
// Three-stage pipeline that splits an item into frame bytes and builds the check byte.
// Depends on tfe_pkg.
module tfe_check
    import tfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_sensor_id,
    input  logic [31:0] i_data_value,
    output logic        o_valid,
    input  logic        i_ready,
    output t_frame      o_frame
);

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    // data bytes 1..6 of the frame ride along every stage
    logic [5:0][7:0] r_b1, r_b2, r_b3;
    logic [7:0] r_p0, r_p1, r_p2;
    logic [7:0] r_q0, r_q1;
    logic [7:0] r_chk;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_b1 <= {i_data_value, i_sensor_id};
            r_p0 <= eac_add(FRAME_TYPE, i_sensor_id[7:0]);
            r_p1 <= eac_add(i_sensor_id[15:8], i_data_value[7:0]);
            r_p2 <= eac_add(i_data_value[15:8], i_data_value[23:16]);
        end
        if (en2) begin
            r_b2 <= r_b1;
            r_q0 <= eac_add(r_p0, r_p1);
            r_q1 <= eac_add(r_p2, r_b1[5]);
        end
        if (en3) begin
            r_b3  <= r_b2;
            r_chk <= CHECK_BASE - eac_add(r_q0, r_q1);
        end
    end

    assign o_valid = r_v3;
    assign o_frame = {r_chk, r_b3, FRAME_TYPE};

endmodule

@@ hdl/tfe_serial.sv @@
// Byte serializer with escaping and a registered output word.
// Depends on tfe_pkg.
module tfe_serial
    import tfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_frame     i_frame,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_wire_byte,
    output logic       o_frame_end
);

    t_frame           r_frame;
    logic [IDX_W-1:0] r_idx;
    logic             r_half;
    logic             r_busy;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_end;

    logic [7:0] cur;
    logic       cur_esc;
    logic       adv;
    logic       last;
    logic       load;

    always_comb begin
        cur     = r_frame[r_idx];
        cur_esc = needs_esc(cur);
        adv     = r_busy && (!r_out_valid || i_ready);
        last    = (r_idx == IDX_W'(FRAME_BYTES - 1)) && (!cur_esc || r_half);
        load    = i_valid && (!r_busy || (adv && last));
    end

    assign o_ready = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_half      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            // take the next frame as the last word of this one goes out
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_half <= 1'b0;
            end else if (adv) begin
                if (cur_esc && !r_half) begin
                    r_half <= 1'b1;
                end else begin
                    r_half <= 1'b0;
                    r_idx  <= r_idx + 1'b1;
                    if (last) r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_frame <= i_frame;
        if (adv) begin
            if (cur_esc && !r_half) begin
                r_out_byte <= ESC_MARK;
                r_out_end  <= 1'b0;
            end else begin
                r_out_byte <= r_half ? (cur & ~ESC_FLIP & BYTE_MASK) : cur;
                r_out_end  <= last;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_wire_byte = r_out_byte;
    assign o_frame_end = r_out_end;

endmodule
